// ----- sv/btgr_pkg.sv -----
`timescale 1ns / 1ps

package btgr_pkg;

	localparam int GLYPH_ROWS = 7;
	localparam int GLYPH_COLS = 5;
	localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;
	localparam int GLYPH_COUNT = 40;

	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_SCALE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_CLIP_RIGHT = 1'd1;

	localparam logic [4:0] SCALE_RESET = 5'd1;
	localparam logic [15:0] CLIP_RESET = 16'h7fff;
	localparam logic [15:0] CLIP_MARGIN = 16'd8;

	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_COLON = 8'h3a;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	localparam logic [5:0] IDX_DIGIT0 = 6'd26;
	localparam logic [5:0] IDX_COLON = 6'd36;
	localparam logic [5:0] IDX_MINUS = 6'd37;
	localparam logic [5:0] IDX_SPACE = 6'd38;
	localparam logic [5:0] IDX_QUESTION = 6'd39;

	typedef logic [GLYPH_BITS-1:0] glyph_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ADV,
		ST_MARK
	} state_t;

	// Rows are packed top row first; within a row the leftmost pixel is the MSB.
	localparam glyph_t GLYPH_ROM [GLYPH_COUNT] = '{
		{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
		{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
		{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
		{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
		{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
		{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
		{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
		{5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd31},
		{5'd7, 5'd2, 5'd2, 5'd2, 5'd2, 5'd18, 5'd12},
		{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
		{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
		{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
		{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
		{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
		{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
		{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
		{5'd15, 5'd16, 5'd16, 5'd14, 5'd1, 5'd1, 5'd30},
		{5'd31, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4},
		{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
		{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
		{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
		{5'd17, 5'd17, 5'd10, 5'd4, 5'd10, 5'd17, 5'd17},
		{5'd17, 5'd17, 5'd10, 5'd4, 5'd4, 5'd4, 5'd4},
		{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd31},
		{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
		{5'd4, 5'd12, 5'd4, 5'd4, 5'd4, 5'd4, 5'd14},
		{5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd8, 5'd31},
		{5'd30, 5'd1, 5'd1, 5'd14, 5'd1, 5'd1, 5'd30},
		{5'd2, 5'd6, 5'd10, 5'd18, 5'd31, 5'd2, 5'd2},
		{5'd31, 5'd16, 5'd16, 5'd30, 5'd1, 5'd1, 5'd30},
		{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
		{5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd8, 5'd8},
		{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
		{5'd14, 5'd17, 5'd17, 5'd15, 5'd1, 5'd1, 5'd14},
		{5'd0, 5'd12, 5'd12, 5'd0, 5'd12, 5'd12, 5'd0},
		{5'd0, 5'd0, 5'd0, 5'd14, 5'd0, 5'd0, 5'd0},
		{5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0},
		{5'd14, 5'd17, 5'd1, 5'd2, 5'd4, 5'd0, 5'd4}
	};

	// Maps a character byte to its ROM entry; lowercase folds to uppercase.
	function automatic logic [5:0] glyph_index(input logic [7:0] code);
		logic [7:0] c;
		logic [7:0] d;
		logic [5:0] idx;
		c = code;
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			c = c - CHAR_LOWER_A + CHAR_UPPER_A;
		end
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			d = c - CHAR_UPPER_A;
			idx = d[5:0];
		end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d = c - CHAR_ZERO;
			idx = IDX_DIGIT0 + d[5:0];
		end else if (c == CHAR_COLON) begin
			idx = IDX_COLON;
		end else if (c == CHAR_MINUS) begin
			idx = IDX_MINUS;
		end else if (c == CHAR_SPACE) begin
			idx = IDX_SPACE;
		end else begin
			idx = IDX_QUESTION;
		end
		return idx;
	endfunction

endpackage

// ----- sv/bitmap_text_glyph_rasterizer_core.sv -----
`timescale 1ns / 1ps

// 5x7 bitmap text rasterizer. Each accepted character walks its glyph one
// cell per cycle while the output register is free to take a result,
// emitting the top-left corner of a square for every lit cell, then advances
// the cursor by six times the pixel scale and checks it against the clip edge
// less the clip margin, and then emits the end marker with the running width.
// The glyph scan is a single position stepper over the glyph cells; a full
// output register that is stalled holds both the scan and the marker. A
// character that arrives after the string has stopped at the clip edge, or
// while the scale is zero, gives only the marker. in_stall stays high from
// acceptance until the marker is handed to the output register. Configuration
// writes are always ready and are meant to happen only while the block is
// idle.
module bitmap_text_glyph_rasterizer_core #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [btgr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [15:0]                          cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [7:0]                           char_code,
	input  logic                                 string_start,
	input  logic signed [15:0]                   start_x,
	input  logic signed [15:0]                   start_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [15:0]                   pixel_x,
	output logic signed [15:0]                   pixel_y,
	output logic                                 is_pixel,
	output logic [15:0]                          width_so_far,
	output logic                                 clipped,
	output logic                                 last
);

	localparam int CW = COORD_WIDTH;
	localparam int CMPW = (CW > 16) ? CW + 1 : 17;

	btgr_pkg::state_t state_q, state_d;

	logic [4:0]            scale_q;
	logic [15:0]           clip_q;
	logic [CW-1:0]         cursor_q;
	logic [CW-1:0]         origin_x_q;
	logic [CW-1:0]         origin_y_q;
	logic                  stopped_q;
	btgr_pkg::glyph_t      glyph_q;
	logic [2:0]            gx_q;
	logic [2:0]            gy_q;
	logic [CW-1:0]         col_x_q;
	logic [CW-1:0]         row_y_q;

	logic                  out_valid_q;
	logic [15:0]           pixel_x_q;
	logic [15:0]           pixel_y_q;
	logic                  is_pixel_q;
	logic [15:0]           width_q;
	logic                  clipped_q;
	logic                  last_q;

	logic                  in_xfer;
	logic                  slot_free;
	logic                  stopped_eff;
	logic                  scan_step;
	logic                  scan_done;
	logic                  load_pixel;
	logic                  load_mark;
	logic [CW+15:0]        sx_ext;
	logic [CW+15:0]        sy_ext;
	logic [CW-1:0]         sx_c;
	logic [CW-1:0]         sy_c;
	logic [CW-1:0]         scale_c;
	logic [7:0]            adv;
	logic [CW-1:0]         cursor_next;
	logic signed [CMPW-1:0] cursor_cmp;
	logic signed [CMPW-1:0] limit_cmp;
	logic [CW-1:0]         width_c;
	logic [CW+15:0]        col_ext;
	logic [CW+15:0]        row_ext;
	logic [CW+15:0]        width_ext;

	assign cfg_ready = 1'b1;
	assign in_xfer   = in_valid && !in_stall;
	assign slot_free = !out_valid_q || !out_stall;

	// Origin words follow the coordinate width: sign-extend or truncate.
	assign sx_ext = {{CW{start_x[15]}}, start_x};
	assign sy_ext = {{CW{start_y[15]}}, start_y};
	assign sx_c   = sx_ext[CW-1:0];
	assign sy_c   = sy_ext[CW-1:0];

	assign scale_c     = {{(CW-5){1'b0}}, scale_q};
	assign adv         = {1'b0, scale_q, 2'b00} + {2'b00, scale_q, 1'b0};
	assign cursor_next = cursor_q + {{(CW-8){1'b0}}, adv};
	assign cursor_cmp  = {{(CMPW-CW){cursor_next[CW-1]}}, cursor_next};
	assign limit_cmp   = {{(CMPW-16){clip_q[15]}}, clip_q}
		- {{(CMPW-16){1'b0}}, btgr_pkg::CLIP_MARGIN};

	assign width_c   = cursor_q - origin_x_q;
	assign col_ext   = {16'd0, col_x_q};
	assign row_ext   = {16'd0, row_y_q};
	assign width_ext = {16'd0, width_c};

	assign stopped_eff = string_start ? 1'b0 : stopped_q;
	assign scan_done   = (gx_q == 3'(btgr_pkg::GLYPH_COLS - 1))
		&& (gy_q == 3'(btgr_pkg::GLYPH_ROWS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			btgr_pkg::ST_IDLE: begin
				if (in_xfer) begin
					if (stopped_eff || scale_q == 5'd0) begin
						state_d = btgr_pkg::ST_MARK;
					end else begin
						state_d = btgr_pkg::ST_SCAN;
					end
				end
			end
			btgr_pkg::ST_SCAN: begin
				if (slot_free && scan_done) begin
					state_d = btgr_pkg::ST_ADV;
				end
			end
			btgr_pkg::ST_ADV: begin
				state_d = btgr_pkg::ST_MARK;
			end
			btgr_pkg::ST_MARK: begin
				if (slot_free) begin
					state_d = btgr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = btgr_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		scan_step = 1'b0;
		load_mark = 1'b0;
		unique case (state_q)
			btgr_pkg::ST_IDLE: in_stall = 1'b0;
			btgr_pkg::ST_SCAN: scan_step = slot_free;
			btgr_pkg::ST_ADV:  in_stall = 1'b1;
			btgr_pkg::ST_MARK: load_mark = slot_free;
			default:           in_stall = 1'b1;
		endcase
	end

	assign load_pixel = scan_step && glyph_q[btgr_pkg::GLYPH_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= btgr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= btgr_pkg::SCALE_RESET;
			clip_q  <= btgr_pkg::CLIP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				btgr_pkg::CFG_PIXEL_SCALE: scale_q <= cfg_data[4:0];
				btgr_pkg::CFG_CLIP_RIGHT:  clip_q <= cfg_data;
				default:                   scale_q <= scale_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q   <= '0;
			origin_x_q <= '0;
			origin_y_q <= '0;
			stopped_q  <= 1'b0;
		end else if (in_xfer && string_start) begin
			cursor_q   <= sx_c;
			origin_x_q <= sx_c;
			origin_y_q <= sy_c;
			stopped_q  <= 1'b0;
		end else if (state_q == btgr_pkg::ST_ADV) begin
			cursor_q <= cursor_next;
			if (cursor_cmp > limit_cmp) begin
				stopped_q <= 1'b1;
			end
		end
	end

	// Scan position: glyph shifts left so its MSB is always the current cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gx_q <= '0;
			gy_q <= '0;
		end else if (in_xfer) begin
			gx_q <= '0;
			gy_q <= '0;
		end else if (scan_step) begin
			if (gx_q == 3'(btgr_pkg::GLYPH_COLS - 1)) begin
				gx_q <= '0;
				gy_q <= gy_q + 3'd1;
			end else begin
				gx_q <= gx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			glyph_q <= btgr_pkg::GLYPH_ROM[btgr_pkg::glyph_index(char_code)];
			col_x_q <= string_start ? sx_c : cursor_q;
			row_y_q <= string_start ? sy_c : origin_y_q;
		end else if (scan_step) begin
			glyph_q <= {glyph_q[btgr_pkg::GLYPH_BITS-2:0], 1'b0};
			if (gx_q == 3'(btgr_pkg::GLYPH_COLS - 1)) begin
				col_x_q <= cursor_q;
				row_y_q <= row_y_q + scale_c;
			end else begin
				col_x_q <= col_x_q + scale_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_pixel || load_mark) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_pixel) begin
			pixel_x_q  <= col_ext[15:0];
			pixel_y_q  <= row_ext[15:0];
			is_pixel_q <= 1'b1;
			width_q    <= '0;
			clipped_q  <= 1'b0;
			last_q     <= 1'b0;
		end else if (load_mark) begin
			pixel_x_q  <= '0;
			pixel_y_q  <= '0;
			is_pixel_q <= 1'b0;
			width_q    <= width_ext[15:0];
			clipped_q  <= stopped_q;
			last_q     <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign is_pixel     = is_pixel_q;
	assign width_so_far = width_q;
	assign clipped      = clipped_q;
	assign last         = last_q;

	a_scan_only_live: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == btgr_pkg::ST_SCAN |-> !stopped_q && scale_q != 5'd0)
		else $error("glyph scan running on a stopped string or zero scale");

	a_idle_holds_marker: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == btgr_pkg::ST_IDLE && out_valid_q |-> last_q && !is_pixel_q)
		else $error("idle with a pending result that is not the end marker");

	a_pixel_in_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		load_pixel |-> gx_q < 3'(btgr_pkg::GLYPH_COLS) && gy_q < 3'(btgr_pkg::GLYPH_ROWS))
		else $error("lit cell outside the glyph area");

	a_marker_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		load_mark |=> state_q == btgr_pkg::ST_IDLE && out_valid_q && last_q)
		else $error("end marker did not close the character");

	a_clip_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q && !in_xfer |=> stopped_q)
		else $error("clip stop cleared without a new string");

endmodule
